// ===== hw/rtl/brs_pkg.sv =====
// ----------------------------------------------------------------------------
// Block reassembler package
// Shared constants, result transaction types and queue push bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package brs_pkg;

    // Default number of payload bytes in one block.
    localparam int PAYLOAD_BYTES_DEF = 60;

    // Header bytes in front of the payload: type, reserved, size low, size high.
    localparam int HDR_BYTES = 4;

    // Header byte positions.
    localparam int POS_TYPE     = 0;
    localparam int POS_SIZE_LOW = 2;
    localparam int POS_SIZE_HI  = 3;

    // Flag bits of the type byte.
    localparam int FLAG_FIRST_BIT = 0;
    localparam int FLAG_LAST_BIT  = 2;

    // Reset value of the buffer capacity register.
    localparam logic [15:0] CAP_RESET = 16'hFFFF;

    // Default depth of the result queue (power of two, at least four).
    localparam int QUEUE_DEPTH_DEF = 8;

    // Result kinds.
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    // One result transaction.
    typedef struct packed {
        logic        kind;
        logic [7:0]  data;
        logic [15:0] offset;
        logic [15:0] length;
    } result_t;

    // Up to two results pushed into the queue in one cycle, first slot first.
    typedef struct packed {
        logic [1:0] num;
        result_t    r0;
        result_t    r1;
    } push_t;

endpackage

`default_nettype wire

// ===== hw/rtl/brs_parser.sv =====
// ----------------------------------------------------------------------------
// Block reassembler parser
// Registers each accepted byte, tracks the block position and the session,
// and produces up to two result transactions per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module brs_parser
    import brs_pkg::*;
#(
    parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        accept,
    input  wire logic [7:0]  block_byte,
    input  wire logic [15:0] capacity,
    output push_t            push
);

    localparam int BLOCK_BYTES = PAYLOAD_BYTES + HDR_BYTES;
    localparam int POS_W       = $clog2(BLOCK_BYTES);
    localparam int CNT_W       = $clog2(PAYLOAD_BYTES + 1);

    localparam logic [POS_W-1:0] LAST_POS  = POS_W'(BLOCK_BYTES - 1);
    localparam logic [POS_W-1:0] P_TYPE    = POS_W'(POS_TYPE);
    localparam logic [POS_W-1:0] P_LOW     = POS_W'(POS_SIZE_LOW);
    localparam logic [POS_W-1:0] P_HI      = POS_W'(POS_SIZE_HI);
    localparam logic [POS_W-1:0] P_PAYLOAD = POS_W'(HDR_BYTES);
    localparam logic [15:0]      PAY_16    = 16'(PAYLOAD_BYTES);

    // Input register.
    logic            vld_reg;
    logic [7:0]      byte_reg;

    // Block and session state.
    logic [POS_W-1:0] pos_reg,    pos_next;
    logic [7:0]       type_reg,   type_next;
    logic [7:0]       low_reg,    low_next;
    logic [15:0]      total_reg,  total_next;
    logic [15:0]      rcvd_reg,   rcvd_next;
    logic             active_reg, active_next;
    logic [CNT_W-1:0] copy_reg,   copy_next;

    // Header decision terms.
    logic             first;
    logic [15:0]      hdr_total;
    logic [15:0]      base_total;
    logic [15:0]      base_rcvd;
    logic [15:0]      limit;
    logic [15:0]      diff;
    logic [POS_W-1:0] idx;
    logic             emit_data;
    logic             emit_done;
    result_t          res_data;
    result_t          res_done;

    // Input register: byte valid flag is control, the byte is payload.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= block_byte;
        end
    end

    // Header decision, settled when the size high byte arrives. A first flag
    // takes the size from the header and starts counting from zero.
    assign first      = type_reg[FLAG_FIRST_BIT];
    assign hdr_total  = {byte_reg, low_reg};
    assign base_total = first ? hdr_total : total_reg;
    assign base_rcvd  = first ? 16'd0 : rcvd_reg;
    assign limit      = (base_total < capacity) ? base_total : capacity;
    assign diff       = limit - base_rcvd;
    assign idx        = pos_reg - P_PAYLOAD;

    // Next state and result selection for the byte held in the input register.
    always_comb
    begin
        pos_next    = pos_reg;
        type_next   = type_reg;
        low_next    = low_reg;
        total_next  = total_reg;
        rcvd_next   = rcvd_reg;
        active_next = active_reg;
        copy_next   = copy_reg;
        emit_data   = 1'b0;
        emit_done   = 1'b0;

        if (vld_reg)
        begin
            if (pos_reg == P_TYPE)
            begin
                type_next = byte_reg;
            end
            else if (pos_reg == P_LOW)
            begin
                low_next = byte_reg;
            end
            else if (pos_reg == P_HI)
            begin
                if (first)
                begin
                    total_next  = hdr_total;
                    rcvd_next   = 16'd0;
                    active_next = 1'b1;
                end
                // Capacity at or below the count leaves limit <= count.
                if (active_next && (limit > rcvd_next))
                begin
                    copy_next = (diff < PAY_16) ? CNT_W'(diff) : CNT_W'(PAYLOAD_BYTES);
                end
                else
                begin
                    copy_next = '0;
                end
            end
            else if (pos_reg >= P_PAYLOAD)
            begin
                if (active_reg && (idx < POS_W'(copy_reg)))
                begin
                    emit_data = 1'b1;
                    rcvd_next = rcvd_reg + 16'd1;
                end
            end

            // End of block: completion for an active session with the last flag.
            if (pos_reg == LAST_POS)
            begin
                if (active_reg && type_reg[FLAG_LAST_BIT])
                begin
                    emit_done   = 1'b1;
                    active_next = 1'b0;
                end
                pos_next = '0;
            end
            else
            begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    // Result transactions.
    always_comb
    begin
        res_data.kind   = KIND_DATA;
        res_data.data   = byte_reg;
        res_data.offset = rcvd_reg;
        res_data.length = 16'd0;

        res_done.kind   = KIND_DONE;
        res_done.data   = 8'd0;
        res_done.offset = 16'd0;
        res_done.length = rcvd_next;

        push.r0  = emit_data ? res_data : res_done;
        push.r1  = res_done;
        push.num = {1'b0, emit_data} + {1'b0, emit_done};
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            type_reg   <= 8'd0;
            low_reg    <= 8'd0;
            total_reg  <= 16'd0;
            rcvd_reg   <= 16'd0;
            active_reg <= 1'b0;
            copy_reg   <= '0;
        end
        else
        begin
            pos_reg    <= pos_next;
            type_reg   <= type_next;
            low_reg    <= low_next;
            total_reg  <= total_next;
            rcvd_reg   <= rcvd_next;
            active_reg <= active_next;
            copy_reg   <= copy_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/brs_queue.sv =====
// ----------------------------------------------------------------------------
// Block reassembler result queue
// Small register queue that takes up to two results a cycle and hands out
// one result transaction a cycle on the output channel while it is popped.
// ----------------------------------------------------------------------------
`default_nettype none

module brs_queue
    import brs_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire push_t push,
    input  wire logic  pop,
    output result_t    head,
    output logic       not_empty,
    output logic       near_full
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Room kept for the byte in the input register and one more accepted byte.
    localparam logic [CNT_W-1:0] STALL_LEVEL = CNT_W'(DEPTH - 4);

    result_t          mem [DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [PTR_W-1:0] wr_alt;

    assign wr_alt    = wr_reg + PTR_W'(1);
    assign head      = mem[rd_reg];
    assign not_empty = (cnt_reg != '0);
    assign near_full = (cnt_reg > STALL_LEVEL);

    // Pointer and level update.
    always_comb
    begin
        wr_next  = wr_reg + PTR_W'(push.num);
        rd_next  = pop ? (rd_reg + PTR_W'(1)) : rd_reg;
        cnt_next = cnt_reg + CNT_W'(push.num) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Storage writes: first slot at the write pointer, second right after it.
    always_ff @(posedge clk)
    begin
        if (push.num != 2'd0)
        begin
            mem[wr_reg] <= push.r0;
        end
        if (push.num == 2'd2)
        begin
            mem[wr_alt] <= push.r1;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/block_reassembler.sv =====
// ----------------------------------------------------------------------------
// Block reassembler
// Rebuilds messages from a stream of fixed-size blocks with first, middle and
// last flags, delivering payload bytes with offsets and a completion result.
// ----------------------------------------------------------------------------
// Usage:
// Input channel (byte_valid, byte_stall, block_byte) carries one stream byte
// per transaction, blocks back to back, each PAYLOAD_BYTES + 4 bytes long.
// Output channel (result_valid, result_stall, kind, data, offset, length)
// carries one result per transaction: a payload byte with its message offset,
// or a completion with the delivered length after a block with the last flag.
// Configuration channel (cfg_valid, cfg_ready, cfg_data) writes the buffer
// capacity; cfg_ready is always high. Write it only while the block is idle.
// Throughput is one byte per cycle while byte_stall is low. A byte is processed
// in the cycle after it is accepted and its results enter the queue at the next
// edge, so with an empty queue its first result is offered once it has passed
// the input register and been written into the queue. A block gives at most
// PAYLOAD_BYTES + 1 results, so the one-result-per-cycle output keeps up.
// When the receiver stalls, results collect in the queue and byte_stall rises
// once fewer than four entries are free; no result is lost.
// Reset clears the position, the session and the queue, and sets the capacity
// to 65535. The block accepts bytes as soon as reset is released.
// ----------------------------------------------------------------------------
`default_nettype none

module block_reassembler
    import brs_pkg::*;
#(
    parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF,
    parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        byte_valid,
    output logic             byte_stall,
    input  wire logic [7:0]  block_byte,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data,
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic             kind,
    output logic [7:0]       data,
    output logic [15:0]      offset,
    output logic [15:0]      length
);

    logic [15:0] capacity_reg;
    logic        near_full;
    logic        accept;
    push_t       push;
    result_t     head;

    // Capacity register, written by a configuration transaction.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            capacity_reg <= cfg_data;
        end
    end

    // Input flow control from the queue level.
    assign byte_stall = near_full;
    assign accept     = byte_valid && !byte_stall;

    brs_parser #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .block_byte (block_byte),
        .capacity   (capacity_reg),
        .push       (push)
    );

    brs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (result_valid && !result_stall),
        .head      (head),
        .not_empty (result_valid),
        .near_full (near_full)
    );

    // Output fields from the queue head.
    assign kind   = head.kind;
    assign data   = head.data;
    assign offset = head.offset;
    assign length = head.length;

endmodule

`default_nettype wire

// ===== hw/rtl/brs_checker.sv =====
// ----------------------------------------------------------------------------
// Block reassembler checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module brs_checker
    import brs_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        result_valid,
    input wire logic        result_stall,
    input wire logic        kind,
    input wire logic [7:0]  data,
    input wire logic [15:0] offset,
    input wire logic [15:0] length
);

    // A stalled result transaction holds its fields.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=>
            result_valid && $stable(kind) && $stable(data) &&
            $stable(offset) && $stable(length))
        else $error("stalled result changed");

    // A completion carries no byte and no offset.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (kind == KIND_DONE) |-> (data == 8'd0) && (offset == 16'd0))
        else $error("completion with data or offset");

    // A payload byte carries no length.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (kind == KIND_DATA) |-> (length == 16'd0))
        else $error("payload byte with length");

    // Nothing is offered right after reset.
    assert property (@(posedge clk)
        !rst_n |=> !result_valid)
        else $error("result offered after reset");

endmodule

bind block_reassembler brs_checker u_brs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .kind         (kind),
    .data         (data),
    .offset       (offset),
    .length       (length)
);

`default_nettype wire
